FILE: hdl/ntc_pkg.sv
package ntc_pkg;

	localparam int TABLE_ENTRIES_DEF = 100;
	localparam int CURVE_CONSTANTS   = 100;
	localparam int CODE_W            = 12;
	localparam int CFG_W             = 13;
	localparam int TEMP_W            = 17;
	localparam int SUM_W             = 22;
	localparam int FRAC_W            = 12;
	localparam int REM_W             = 26;
	localparam int SHORT_TEMP_Q8     = 35840;
	localparam int TEMP_MAX_Q8       = 65535;
	localparam int TEMP_MIN_Q8       = -65536;

	localparam logic [12:0] SHORT_THR_RST = 13'd300;
	localparam logic [12:0] OPEN_THR_RST  = 13'd4500;
	localparam logic [7:0]  START_T_RST   = 8'd0;
	localparam logic [3:0]  DPE_RST       = 4'd1;

	typedef enum logic [1:0] {
		ST_NORMAL = 2'd0,
		ST_SHORT  = 2'd1,
		ST_OPEN   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_SHORT_THR = 2'd0,
		CFG_OPEN_THR  = 2'd1,
		CFG_START_T   = 2'd2,
		CFG_DPE       = 2'd3
	} cfg_idx_t;

	// micro-ops of the sequencer
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_CLASS,
		OP_PROBE,
		OP_NARROW,
		OP_FETCH,
		OP_DIV_INIT,
		OP_DIV,
		OP_COMPOSE
	} uop_t;

	// jump conditions; jump taken when true, else fall through
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NSTART,
		C_NOSEARCH,
		C_BRACKETED,
		C_DIV_MORE
	} cond_t;

	typedef logic [2:0] step_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} uword_t;

	localparam step_t STEP_IDLE     = 3'd0;
	localparam step_t STEP_CLASS    = 3'd1;
	localparam step_t STEP_PROBE    = 3'd2;
	localparam step_t STEP_NARROW   = 3'd3;
	localparam step_t STEP_FETCH    = 3'd4;
	localparam step_t STEP_DIV_INIT = 3'd5;
	localparam step_t STEP_DIV      = 3'd6;
	localparam step_t STEP_COMPOSE  = 3'd7;
	localparam int    UCODE_LEN     = 8;

	localparam uword_t UCODE [UCODE_LEN] = '{
		'{OP_IDLE,     C_NSTART,    STEP_IDLE},
		'{OP_CLASS,    C_NOSEARCH,  STEP_COMPOSE},
		'{OP_PROBE,    C_BRACKETED, STEP_FETCH},
		'{OP_NARROW,   C_ALWAYS,    STEP_PROBE},
		'{OP_FETCH,    C_NEVER,     STEP_IDLE},
		'{OP_DIV_INIT, C_NEVER,     STEP_IDLE},
		'{OP_DIV,      C_DIV_MORE,  STEP_DIV},
		'{OP_COMPOSE,  C_ALWAYS,    STEP_IDLE}
	};

	localparam logic [11:0] CURVE [CURVE_CONSTANTS] = '{
		12'd3072, 12'd3037, 12'd3002, 12'd2966, 12'd2930,
		12'd2894, 12'd2857, 12'd2819, 12'd2782, 12'd2743,
		12'd2705, 12'd2666, 12'd2627, 12'd2588, 12'd2548,
		12'd2509, 12'd2469, 12'd2429, 12'd2389, 12'd2349,
		12'd2310, 12'd2270, 12'd2230, 12'd2190, 12'd2150,
		12'd2111, 12'd2072, 12'd2032, 12'd1993, 12'd1955,
		12'd1916, 12'd1878, 12'd1841, 12'd1803, 12'd1766,
		12'd1730, 12'd1693, 12'd1658, 12'd1622, 12'd1587,
		12'd1553, 12'd1519, 12'd1486, 12'd1453, 12'd1420,
		12'd1388, 12'd1357, 12'd1326, 12'd1295, 12'd1265,
		12'd1236, 12'd1207, 12'd1179, 12'd1151, 12'd1124,
		12'd1098, 12'd1071, 12'd1046, 12'd1021, 12'd996,
		12'd972,  12'd949,  12'd926,  12'd904,  12'd882,
		12'd860,  12'd839,  12'd819,  12'd799,  12'd779,
		12'd760,  12'd741,  12'd723,  12'd705,  12'd688,
		12'd671,  12'd655,  12'd639,  12'd623,  12'd608,
		12'd593,  12'd578,  12'd564,  12'd550,  12'd537,
		12'd524,  12'd511,  12'd498,  12'd486,  12'd474,
		12'd463,  12'd452,  12'd441,  12'd430,  12'd420,
		12'd410,  12'd400,  12'd390,  12'd381,  12'd372
	};

	// slots past the stored curve repeat its last point
	function automatic logic [11:0] curve_rd(input logic [7:0] idx);
		logic [7:0] i;
		i = (idx >= 8'(CURVE_CONSTANTS)) ? 8'(CURVE_CONSTANTS - 1) : idx;
		return CURVE[i[6:0]];
	endfunction

endpackage

FILE: hdl/ntc_thermistor_table_interp_top.sv
// NTC thermistor reading to temperature. Raise start for one cycle while busy is
// low to hand in a 12-bit adc_code; that is one transaction. The block answers with
// exactly one result: done is high for a single cycle with temperature (signed Q9.8
// degrees) and sensor_status (0 normal, 1 shorted, 2 open). The receiver cannot hold
// the result off, so sample it on the done cycle. A shorted or open sensor, or a code
// beyond either end of the curve, goes from classification straight to compose. A code
// inside the curve takes a binary search over the curve table (a probe and a narrowing
// step per halving, at most ceil(log2(TABLE_ENTRIES-1)) halvings, 6 or 7 for 100 entries
// depending on the code), then a fetch of the bracketing entries, divider set-up, a
// shift-subtract division for the 12-bit fraction, and compose. One item is in flight
// at a time; busy is high from the accepting edge until the done cycle. Configuration
// writes go through cfg_we, cfg_index, cfg_data and should only happen while busy is
// low.
module ntc_thermistor_table_interp_top #(
	parameter int TABLE_ENTRIES = ntc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ntc_pkg::CODE_W-1:0]        adc_code,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [ntc_pkg::CFG_W-1:0]         cfg_data,
	output logic                              done,
	output logic signed [ntc_pkg::TEMP_W-1:0] temperature,
	output logic [1:0]                        sensor_status
);
	import ntc_pkg::*;

	localparam int IDX_W  = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int PROD_W = IDX_W + 4;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// configuration registers
	logic [12:0]       short_thr_q;
	logic [12:0]       open_thr_q;
	logic signed [7:0] start_t_q;
	logic [3:0]        dpe_q;

	// sequencer
	step_t  pc_q, pc_d;
	uword_t uw;
	logic   cond_hit;

	// datapath
	logic [CODE_W-1:0]  code_q;
	logic [IDX_W-1:0]   lo_q, hi_q, mid_q;
	logic [IDX_W:0]     mid_sum;
	logic [IDX_W-1:0]   mid_w;
	logic [11:0]        probe_q;
	logic [11:0]        num_q, den_q;
	logic [REM_W-1:0]   rem_q, dv_q;
	logic [FRAC_W-1:0]  quot_q;
	logic [3:0]         cnt_q;
	status_t            status_q;

	// classification of the held code
	logic is_short, is_open, is_above, is_below;
	logic [11:0] rom_lo, rom_hi;

	// compose
	logic [PROD_W-1:0]       prod;
	logic signed [SUM_W-1:0] sum_w;
	logic signed [TEMP_W-1:0] temp_w;
	logic [FRAC_W-1:0]       frac_w;

	logic                     done_q;
	logic signed [TEMP_W-1:0] temp_q;
	status_t                  status_out_q;

	assign busy          = (pc_q != STEP_IDLE);
	assign done          = done_q;
	assign temperature   = temp_q;
	assign sensor_status = status_out_q;

	// ---------------- configuration port ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_thr_q <= SHORT_THR_RST;
			open_thr_q  <= OPEN_THR_RST;
			start_t_q   <= START_T_RST;
			dpe_q       <= DPE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SHORT_THR: short_thr_q <= cfg_data;
				CFG_OPEN_THR:  open_thr_q  <= cfg_data;
				CFG_START_T:   start_t_q   <= cfg_data[7:0];
				CFG_DPE:       dpe_q       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ---------------- classification ----------------
	assign is_short = ({1'b0, code_q} <= short_thr_q);
	assign is_open  = ({1'b0, code_q} >= open_thr_q);
	assign is_above = (code_q >= curve_rd(8'd0));
	assign is_below = (code_q <= curve_rd(8'(LAST_IDX)));

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w   = mid_sum[IDX_W:1];
	assign rom_lo  = curve_rd(8'(lo_q));
	assign rom_hi  = curve_rd(8'(hi_q));

	// ---------------- sequencer: control word and next step ----------------
	assign uw = UCODE[pc_q];

	always_comb begin
		unique case (uw.cond)
			C_NEVER:     cond_hit = 1'b0;
			C_ALWAYS:    cond_hit = 1'b1;
			C_NSTART:    cond_hit = !start;
			C_NOSEARCH:  cond_hit = is_short || is_open || is_above || is_below;
			C_BRACKETED: cond_hit = ((hi_q - lo_q) <= IDX_W'(1));
			C_DIV_MORE:  cond_hit = (cnt_q != 4'd0);
			default:     cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		pc_d = cond_hit ? uw.target : step_t'(pc_q + 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// ---------------- result compose ----------------
	// fraction only counts on a strictly falling segment with a nonzero offset
	assign frac_w = (num_q != 12'd0 && den_q != 12'd0) ? quot_q : '0;
	assign prod   = PROD_W'(dpe_q) * PROD_W'(lo_q);

	always_comb begin
		sum_w = SUM_W'({{6{start_t_q[7]}}, start_t_q, 8'b0})
			+ $signed(SUM_W'({prod, 8'b0}))
			+ $signed(SUM_W'(frac_w));
		if (sum_w > SUM_W'(TEMP_MAX_Q8)) begin
			temp_w = TEMP_W'(TEMP_MAX_Q8);
		end else if (sum_w < SUM_W'(TEMP_MIN_Q8)) begin
			temp_w = TEMP_W'(TEMP_MIN_Q8);
		end else begin
			temp_w = sum_w[TEMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (uw.op == OP_COMPOSE);
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_IDLE: begin
				if (start) begin
					code_q <= adc_code;
				end
			end
			OP_CLASS: begin
				hi_q  <= LAST_IDX;
				num_q <= '0;
				den_q <= '0;
				lo_q  <= (!is_short && !is_open && !is_above && is_below) ? LAST_IDX : '0;
				if (is_short) begin
					status_q <= ST_SHORT;
				end else if (is_open) begin
					status_q <= ST_OPEN;
				end else begin
					status_q <= ST_NORMAL;
				end
			end
			OP_PROBE: begin
				mid_q   <= mid_w;
				probe_q <= curve_rd(8'(mid_w));
			end
			OP_NARROW: begin
				if (probe_q >= code_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q;
				end
			end
			OP_FETCH: begin
				num_q <= rom_lo - code_q;
				den_q <= rom_lo - rom_hi;
			end
			OP_DIV_INIT: begin
				// n = num*dpe*512 + den, divided by 2*den below
				rem_q  <= REM_W'({16'(num_q) * 16'(dpe_q), 9'b0}) + REM_W'(den_q);
				dv_q   <= REM_W'({den_q, 12'b0});
				quot_q <= '0;
				cnt_q  <= 4'(FRAC_W - 1);
			end
			OP_DIV: begin
				if (rem_q >= dv_q) begin
					rem_q  <= rem_q - dv_q;
					quot_q <= {quot_q[FRAC_W-2:0], 1'b1};
				end else begin
					quot_q <= {quot_q[FRAC_W-2:0], 1'b0};
				end
				dv_q  <= dv_q >> 1;
				cnt_q <= cnt_q - 4'd1;
			end
			OP_COMPOSE: begin
				status_out_q <= status_q;
				unique case (status_q)
					ST_SHORT: temp_q <= TEMP_W'(SHORT_TEMP_Q8);
					ST_OPEN:  temp_q <= '0;
					default:  temp_q <= temp_w;
				endcase
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result strobe without a transaction in flight");

	a_open_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && sensor_status == ST_OPEN) |-> (temperature == '0))
		else $error("open sensor result carries a temperature");
`endif

endmodule

FILE: tb/ntc_thermistor_table_interp_checker.sv
module ntc_thermistor_table_interp_checker
	import ntc_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [CODE_W-1:0]        adc_code,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     done,
	input  logic signed [TEMP_W-1:0] temperature,
	input  logic [1:0]               sensor_status,
	output int                       fail_count,
	output int                       pending
);

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		status_t                  status;
	} reading_t;

	// shadow copy of the register file
	logic [CFG_W-1:0]  short_thr;
	logic [CFG_W-1:0]  open_thr;
	logic signed [7:0] start_deg;
	logic [3:0]        step_deg;

	reading_t pending_readings [$];
	int       shown;

	function automatic int curve_at(int idx);
		return int'(CURVE[(idx >= CURVE_CONSTANTS) ? CURVE_CONSTANTS - 1 : idx]);
	endfunction

	function automatic int entry_q8(int idx);
		return int'(start_deg) * 256 + int'(step_deg) * idx * 256;
	endfunction

	function automatic reading_t convert_code(logic [CODE_W-1:0] code);
		reading_t r;
		int c, lo, hi, mid, num, den, frac, t;
		c = int'(code);
		r.status = ST_NORMAL;
		if (c <= int'(short_thr)) begin
			t = SHORT_TEMP_Q8;
			r.status = ST_SHORT;
		end else if (c >= int'(open_thr)) begin
			t = 0;
			r.status = ST_OPEN;
		end else if (c >= curve_at(0)) begin
			t = entry_q8(0);
		end else if (c <= curve_at(TABLE_ENTRIES - 1)) begin
			t = entry_q8(TABLE_ENTRIES - 1);
		end else begin
			// curve falls with index: keep curve[lo] >= code > curve[hi]
			lo = 0;
			hi = TABLE_ENTRIES - 1;
			while (hi - lo > 1) begin
				mid = (lo + hi) >> 1;
				if (curve_at(mid) >= c)
					lo = mid;
				else
					hi = mid;
			end
			num = curve_at(lo) - c;
			den = curve_at(lo) - curve_at(hi);
			frac = 0;
			// round to nearest, half up
			if (den > 0 && num > 0)
				frac = (num * int'(step_deg) * 512 + den) / (2 * den);
			t = entry_q8(lo) + frac;
		end
		if (t > TEMP_MAX_Q8)
			t = TEMP_MAX_Q8;
		if (t < TEMP_MIN_Q8)
			t = TEMP_MIN_Q8;
		r.temp = t[TEMP_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t got, want;
		if (!arst_n) begin
			short_thr <= SHORT_THR_RST;
			open_thr  <= OPEN_THR_RST;
			start_deg <= START_T_RST;
			step_deg  <= DPE_RST;
			pending_readings.delete();
			pending    <= 0;
			fail_count = 0;
			shown      = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SHORT_THR: short_thr <= cfg_data;
					CFG_OPEN_THR:  open_thr  <= cfg_data;
					CFG_START_T:   start_deg <= cfg_data[7:0];
					CFG_DPE:       step_deg  <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (start && !busy)
				pending_readings.push_back(convert_code(adc_code));
			if (done) begin
				got.temp   = temperature;
				got.status = status_t'(sensor_status);
				if (pending_readings.size() == 0) begin
					fail_count++;
					if (shown < 10) begin
						shown++;
						$display("unexpected reading at %0t: temperature %0d status %0d",
							$time, got.temp, int'(got.status));
					end
				end else begin
					want = pending_readings.pop_front();
					if (got.temp !== want.temp || got.status !== want.status) begin
						fail_count++;
						if (shown < 10) begin
							shown++;
							$display("reading mismatch at %0t: temperature exp %0d got %0d, status exp %0d got %0d",
								$time, want.temp, got.temp,
								int'(want.status), int'(got.status));
						end
					end
				end
			end
			pending <= pending_readings.size();
		end
	end

endmodule

FILE: tb/ntc_thermistor_table_interp_top_test.sv
// Stimulus side of the thermistor bench. The checker beside the DUT predicts
// every reading; this module only feeds codes, rewrites the registers between
// phases and gives the verdict.
module ntc_thermistor_table_interp_top_test;
	import ntc_pkg::*;

	localparam int PHASES         = 8;
	localparam int ITEMS_PER_PHASE = 225;
	// the limit sits far above the longest legal stretch without a transaction or
	// result: a busy period, an idle gap, a drain or a register update
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [CODE_W-1:0] adc_code = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	logic busy;
	logic done;
	logic signed [TEMP_W-1:0] temperature;
	logic [1:0] sensor_status;

	int fail_count;
	int pending;
	int idle_cycles = 0;

	// thresholds of the running phase, used to aim codes at the edges
	int cur_short;
	int cur_open;

	// register settings per phase: short, open, start degrees, degrees per entry
	int ph_short [PHASES] = '{300, 0,    2000, 372,  100,  0,    8191, 600};
	int ph_open  [PHASES] = '{4500, 8191, 1500, 3072, 4095, 8191, 0,    2800};
	int ph_start [PHASES] = '{0,   -128, 5,    -40,  127,  -7,   127,  25};
	int ph_step  [PHASES] = '{1,   15,   3,    1,    15,   0,    0,    2};

	always #5 clk = ~clk;

	ntc_thermistor_table_interp_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.adc_code      (adc_code),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.temperature   (temperature),
		.sensor_status (sensor_status)
	);

	ntc_thermistor_table_interp_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.adc_code      (adc_code),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.temperature   (temperature),
		.sensor_status (sensor_status),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Watchdog: any cycle with an accepted transaction or a result clears it.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [CODE_W-1:0] clamp_code(int v);
		if (v < 0)
			return '0;
		if (v > 4095)
			return 12'd4095;
		return CODE_W'(v);
	endfunction

	// Code mix: uniform, inside the curve, near a curve point, near a threshold,
	// and the hard ends of the range and of the curve.
	function automatic logic [CODE_W-1:0] pick_code();
		int jitter;
		jitter = int'($urandom_range(0, 4)) - 2;
		case ($urandom_range(0, 9))
			0, 1, 2: return CODE_W'($urandom_range(0, 4095));
			3, 4, 5: return CODE_W'($urandom_range(373, 3071));
			6, 7:    return clamp_code(int'(CURVE[$urandom_range(0, CURVE_CONSTANTS - 1)])
						+ jitter);
			8:       return clamp_code(($urandom_range(0, 1) ? cur_short : cur_open)
						+ jitter);
			default: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return 12'd4095;
					2: return 12'd372;
					default: return 12'd3072;
				endcase
			end
		endcase
	endfunction

	// Holds start until the DUT takes the transaction. start stays high on
	// return so back-to-back items need no lower/raise in one step.
	task automatic send_code(logic [CODE_W-1:0] code);
		start <= 1'b1;
		adc_code <= code;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Lower start and wait until every predicted reading has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 13))
			@(posedge clk);
	endtask

	// Writes all four registers back to back; only called with the DUT idle.
	task automatic load_registers(int s, int o, int t, int d);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SHORT_THR;
		cfg_data <= CFG_W'(s);
		@(posedge clk);
		cfg_index <= CFG_OPEN_THR;
		cfg_data <= CFG_W'(o);
		@(posedge clk);
		cfg_index <= CFG_START_T;
		cfg_data <= {5'b0, 8'(t)};
		@(posedge clk);
		cfg_index <= CFG_DPE;
		cfg_data <= {9'b0, 4'(d)};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_short = s;
		cur_open = o;
	endtask

	initial begin
		// directed codes for the reset-value setting: both ends of the range,
		// the short threshold edge, both ends of the curve, on-point and
		// one-off-point codes, alternating bit patterns
		logic [CODE_W-1:0] directed [] = '{
			12'd0, 12'd1, 12'd299, 12'd300, 12'd301, 12'd302,
			12'd371, 12'd372, 12'd373, 12'd400, 12'd1000, 12'd2048,
			12'd2049, 12'd3071, 12'd3072, 12'd3073, 12'd4094, 12'd4095,
			12'hAAA, 12'h555, 12'd1236, 12'd1235, 12'd382, 12'd3036
		};
		bit quiet;
		bit last_phase;

		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			last_phase = (p == PHASES - 1);
			load_registers(ph_short[p], ph_open[p], ph_start[p], ph_step[p]);

			if (p == 0) begin
				foreach (directed[i])
					send_code(directed[i]);
			end

			quiet = last_phase;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// switch between bursty and gapless stretches now and then
				if (!last_phase && n % 40 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				send_code(pick_code());
				if (!quiet && $urandom_range(0, 3) == 0)
					idle_burst();
				// occasional full drain in the middle of a phase
				if (!last_phase && $urandom_range(0, 149) == 0)
					drain();
			end

			// registers may only change with nothing in flight
			drain();
		end

		repeat (TAIL_CYCLES)
			@(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
hdl/ntc_pkg.sv
hdl/ntc_thermistor_table_interp_top.sv
tb/ntc_thermistor_table_interp_checker.sv
tb/ntc_thermistor_table_interp_top_test.sv
